// ----- sv/heartbeat_led_envelope_assert.svh -----
// Assertion macros shared by the heartbeat envelope RTL.
// Needs nothing else; the including module supplies clock and reset names.
`ifndef HEARTBEAT_LED_ENVELOPE_ASSERT_SVH
`define HEARTBEAT_LED_ENVELOPE_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define HLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define HLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/hle_pkg.sv -----
// Package for the heartbeat LED envelope: phase codes, register indexes,
// reset values, and the rest/pause length helper. Depends on nothing.
package hle_pkg;

    // Function codes carried by a beat on the input channel.
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Envelope phases.
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_LUB_ATK     = 3'd1,
        PH_LUB_DEC     = 3'd2,
        PH_DUB_ATK     = 3'd3,
        PH_DUB_DEC     = 3'd4,
        PH_REST_DEC    = 3'd5,
        PH_REST_BREATH = 3'd6,
        PH_PAUSE_DRAW  = 3'd7
    } phase_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LUB_PEAK      = 2'd0,
        CFG_DUB_PEAK      = 2'd1,
        CFG_REST_LEVEL    = 2'd2,
        CFG_DECAY_PERCENT = 2'd3
    } cfg_idx_t;

    localparam int BEATS_PER_CYCLE_DEF = 9;

    // Field widths.
    localparam int LEVEL_W = 8;
    localparam int DECAY_W = 7;
    localparam int FC_W    = 6;
    localparam int REST_W  = 5;
    localparam int PAUSE_W = 6;
    localparam int BTE_W   = 4;
    localparam int GAP_W   = 3;
    localparam int BPH_W   = 3;

    // Division by 100 as multiply by ceil(2^21/100) and shift by 21.
    // Exact for every product below 43690, and level*decay stays below 32768.
    localparam int DECAY_SHIFT   = 21;
    localparam int DECAY_SCALE_W = 22;
    localparam logic [DECAY_SCALE_W-1:0] DECAY_RECIP = 22'd20972;
    localparam int PROD_W = LEVEL_W + DECAY_SCALE_W;

    // Reset values.
    localparam logic [LEVEL_W-1:0] LUB_PEAK_RST   = 8'd255;
    localparam logic [LEVEL_W-1:0] DUB_PEAK_RST   = 8'd170;
    localparam logic [LEVEL_W-1:0] REST_LEVEL_RST = 8'd22;
    localparam logic [LEVEL_W-1:0] LEVEL_RST      = 8'd22;
    localparam logic [DECAY_SCALE_W-1:0] DECAY_SCALE_RST = 22'd1635816; // 78 * 20972

    // Envelope constants.
    localparam logic [FC_W-1:0]    LUB_ATK_FRAMES   = 6'd6;
    localparam logic [FC_W-1:0]    LUB_DEC_FRAMES   = 6'd8;
    localparam logic [FC_W-1:0]    DUB_ATK_FRAMES   = 6'd5;
    localparam logic [FC_W-1:0]    DUB_DEC_FRAMES   = 6'd7;
    localparam logic [FC_W-1:0]    REST_DEC_MAX     = 6'd4;
    localparam logic [REST_W-1:0]  ECTOPIC_REST     = 5'd11;
    localparam logic [REST_W-1:0]  REST_BASE        = 5'd21;  // 430 / 20
    localparam logic [PAUSE_W-1:0] PAUSE_BASE       = 6'd32;  // 650 / 20
    localparam logic [BTE_W-1:0]   ECTOPIC_GAP_BASE = 4'd6;
    localparam logic [GAP_W-1:0]   RAND_GAP_MAX     = 3'd4;
    localparam logic [BPH_W-1:0]   BREATH_LAST      = 3'd5;

    // Number of extra frames that a random millisecond count adds to a
    // 20 ms frame base: (base + v) / 20 steps up at v = 10, 30, ..., 130
    // for both the rest base (430) and the pause base (650). Inputs above
    // their legal range land on the top step, which matches clamping them.
    function automatic logic [2:0] rand_steps(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int k = 0; k < 7; k++) begin
            if (v >= 8'(10 + 20 * k)) begin
                n = n + 3'd1;
            end
        end
        return n;
    endfunction

endpackage

// ----- sv/heartbeat_led_envelope.sv -----
// Heartbeat LED envelope, top level: input register, one pass of envelope
// logic, result register. Depends on hle_pkg and heartbeat_led_envelope_assert.svh.
// A beat passes the input register and then the result register; a low out_ready holds it.
// Throughput: one beat per cycle while out_ready stays high; the single pass from the input
//   register to the result register, through one 8x22 multiply, sets the rate.
// Reset clears control, configuration and envelope state at once; no clearing pass follows.
`include "heartbeat_led_envelope_assert.svh"

module heartbeat_led_envelope #(
    parameter int BEATS_PER_CYCLE = hle_pkg::BEATS_PER_CYCLE_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  hle_pkg::cfg_idx_t                cfg_index,
    input  logic [hle_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [7:0]                       cycles,
    input  logic [7:0]                       rand_rest,
    input  logic [hle_pkg::GAP_W-1:0]        rand_gap,
    input  logic [7:0]                       rand_pause,
    input  logic                             abort,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [hle_pkg::LEVEL_W-1:0]      level,
    output logic                             running,
    output logic                             finished
);
    import hle_pkg::*;

    localparam int BEAT_W = $clog2(BEATS_PER_CYCLE + 1);

    // Configuration registers.
    logic [LEVEL_W-1:0]       lub_peak_reg;
    logic [LEVEL_W-1:0]       dub_peak_reg;
    logic [LEVEL_W-1:0]       rest_level_reg;
    logic [DECAY_SCALE_W-1:0] decay_scale_reg;

    // Input stage.
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_func_reg;
    logic [7:0] s1_cycles_reg;
    logic [7:0] s1_rand_rest_reg;
    logic [GAP_W-1:0] s1_rand_gap_reg;
    logic [7:0] s1_rand_pause_reg;
    logic       s1_abort_reg;

    // Envelope state.
    logic [LEVEL_W-1:0] level_reg, level_next;
    phase_t             phase_reg, phase_next;
    logic [FC_W-1:0]    fc_reg, fc_next;
    logic [BEAT_W-1:0]  beat_reg, beat_next;
    logic [7:0]         cycles_left_reg, cycles_left_next;
    logic [BTE_W-1:0]   bte_reg, bte_next;
    logic               seeded_reg, seeded_next;
    logic               ect_reg, ect_next;
    logic [REST_W-1:0]  rest_frames_reg, rest_frames_next;
    logic [PAUSE_W-1:0] pause_reg, pause_next;
    logic [BPH_W-1:0]   bph_reg, bph_next;

    // Result stage.
    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_level_reg, out_level_next;
    logic               out_running_reg, out_running_next;
    logic               out_finished_reg, out_finished_next;

    logic s2_load;

    // Datapath terms.
    logic [GAP_W-1:0]    gap_clamped;
    logic [BTE_W-1:0]    bte_reload;
    logic [REST_W-1:0]   rest_new;
    logic [PAUSE_W-1:0]  pause_new;
    logic [LEVEL_W-1:0]  atk_peak;
    logic signed [8:0]   atk_diff;
    logic signed [8:0]   atk_half;
    logic [8:0]          atk_sum;
    logic [LEVEL_W-1:0]  atk_level;
    logic [PROD_W-1:0]   dec_prod;
    logic [PROD_W-DECAY_SHIFT-1:0] dec_quot;
    logic [LEVEL_W-1:0]  dec_sat;
    logic [LEVEL_W-1:0]  dec_level;
    logic                rest_decay;
    logic [FC_W-1:0]     br_fc;
    logic [FC_W-1:0]     br_fc1;
    logic [BPH_W-1:0]    br_bph;
    logic                br_ect;
    logic [PAUSE_W-1:0]  br_pause;
    logic [FC_W-1:0]     br_len;
    logic [BPH_W-1:0]    br_off;
    logic [8:0]          br_sum;
    logic [LEVEL_W-1:0]  br_level;
    logic [BEAT_W-1:0]   beat_inc;
    logic [7:0]          cycles_dec;

    // Handshake: the input stage moves on whenever the result slot frees up.
    assign s2_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;

    assign out_valid = out_valid_reg;
    assign level     = out_level_reg;
    assign running   = out_running_reg;
    assign finished  = out_finished_reg;

    // Ectopic schedule reload and beat/pause lengths.
    assign gap_clamped = (s1_rand_gap_reg > RAND_GAP_MAX) ? RAND_GAP_MAX : s1_rand_gap_reg;
    assign bte_reload  = ECTOPIC_GAP_BASE + BTE_W'(gap_clamped);
    assign rest_new    = REST_BASE + REST_W'(rand_steps(s1_rand_rest_reg));
    assign pause_new   = PAUSE_BASE + PAUSE_W'(rand_steps(s1_rand_pause_reg));

    // Attack: step halfway to the peak, halving toward zero.
    assign atk_peak  = (phase_reg == PH_LUB_ATK) ? lub_peak_reg : dub_peak_reg;
    assign atk_diff  = $signed({1'b0, atk_peak}) - $signed({1'b0, level_reg});
    assign atk_half  = atk_diff[8] ? ((atk_diff + 9'sd1) >>> 1) : (atk_diff >>> 1);
    assign atk_sum   = {1'b0, level_reg} + $unsigned(atk_half);
    assign atk_level = atk_sum[LEVEL_W-1:0];

    // Decay: level * percent / 100, saturated, then held at the rest floor.
    assign dec_prod  = PROD_W'(level_reg) * PROD_W'(decay_scale_reg);
    assign dec_quot  = dec_prod[PROD_W-1:DECAY_SHIFT];
    assign dec_sat   = (dec_quot > 9'd255) ? 8'd255 : dec_quot[LEVEL_W-1:0];
    assign dec_level = (dec_sat < rest_level_reg) ? rest_level_reg : dec_sat;

    // A rest decay frame, either in the rest phase or right after a pause draw.
    assign rest_decay = (level_reg > rest_level_reg) &&
                        (((phase_reg == PH_REST_DEC) && (fc_reg < REST_DEC_MAX)) ||
                         (phase_reg == PH_PAUSE_DRAW));

    // Breathing frame inputs; entering breathing this frame starts from zero.
    assign br_fc    = (phase_reg == PH_REST_BREATH) ? fc_reg : '0;
    assign br_bph   = (phase_reg == PH_REST_BREATH) ? bph_reg : '0;
    assign br_ect   = (phase_reg == PH_PAUSE_DRAW) ? 1'b0 : ect_reg;
    assign br_pause = (phase_reg == PH_PAUSE_DRAW) ? pause_new : pause_reg;
    assign br_len   = (br_ect || (br_pause == '0)) ? FC_W'(rest_frames_reg) : br_pause;
    assign br_fc1   = br_fc + 1'b1;
    assign br_off   = (br_bph < 3'd3) ? br_bph : (3'd6 - br_bph);
    assign br_sum   = {1'b0, rest_level_reg} + 9'(br_off);
    assign br_level = br_sum[8] ? 8'd255 : br_sum[LEVEL_W-1:0];

    // End-of-beat bookkeeping.
    assign beat_inc   = beat_reg + 1'b1;
    assign cycles_dec = (cycles_left_reg != '0) ? (cycles_left_reg - 8'd1) : cycles_left_reg;

    // Next state and result for the beat leaving the input stage.
    always_comb
    begin
        s1_valid_next     = in_valid && in_ready ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        out_valid_next    = s2_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_level_next    = out_level_reg;
        out_running_next  = out_running_reg;
        out_finished_next = out_finished_reg;

        level_next       = level_reg;
        phase_next       = phase_reg;
        fc_next          = fc_reg;
        beat_next        = beat_reg;
        cycles_left_next = cycles_left_reg;
        bte_next         = bte_reg;
        seeded_next      = seeded_reg;
        ect_next         = ect_reg;
        rest_frames_next = rest_frames_reg;
        pause_next       = pause_reg;
        bph_next         = bph_reg;

        if (s2_load) begin
            out_level_next    = level_reg;
            out_running_next  = 1'b0;
            out_finished_next = 1'b0;

            if (s1_func_reg == FUNC_START) begin
                // Start: load the cycle count and begin a fresh beat.
                if (!seeded_reg) begin
                    bte_next    = bte_reload;
                    seeded_next = 1'b1;
                end
                cycles_left_next = s1_cycles_reg;
                beat_next        = '0;
                fc_next          = '0;
                bph_next         = '0;
                ect_next         = 1'b0;
                pause_next       = '0;
                phase_next       = (s1_cycles_reg != '0) ? PH_LUB_ATK : PH_IDLE;
                out_running_next = (s1_cycles_reg != '0);
            end else if (phase_reg != PH_IDLE) begin
                out_running_next = 1'b1;
                case (phase_reg)
                    PH_LUB_ATK, PH_DUB_ATK:
                    begin
                        // The first lub frame opens the beat.
                        if ((phase_reg == PH_LUB_ATK) && (fc_reg == '0)) begin
                            if (bte_reg <= 4'd1) begin
                                bte_next         = bte_reload;
                                ect_next         = 1'b1;
                                rest_frames_next = ECTOPIC_REST;
                            end else begin
                                bte_next         = bte_reg - 4'd1;
                                ect_next         = 1'b0;
                                rest_frames_next = rest_new;
                            end
                            pause_next = '0;
                        end
                        level_next     = atk_level;
                        out_level_next = atk_level;
                        if ((fc_reg + 1'b1) >= ((phase_reg == PH_LUB_ATK) ?
                                                LUB_ATK_FRAMES : DUB_ATK_FRAMES)) begin
                            phase_next = (phase_reg == PH_LUB_ATK) ? PH_LUB_DEC : PH_DUB_DEC;
                            fc_next    = '0;
                        end else begin
                            fc_next = fc_reg + 1'b1;
                        end
                    end
                    PH_LUB_DEC, PH_DUB_DEC:
                    begin
                        level_next     = dec_level;
                        out_level_next = dec_level;
                        if ((fc_reg + 1'b1) >= ((phase_reg == PH_LUB_DEC) ?
                                                LUB_DEC_FRAMES : DUB_DEC_FRAMES)) begin
                            phase_next = (phase_reg == PH_LUB_DEC) ? PH_DUB_ATK : PH_REST_DEC;
                            fc_next    = '0;
                        end else begin
                            fc_next = fc_reg + 1'b1;
                        end
                    end
                    PH_REST_DEC, PH_REST_BREATH, PH_PAUSE_DRAW:
                    begin
                        // A pause draw sets the pause length and falls into the rest.
                        if (phase_reg == PH_PAUSE_DRAW) begin
                            pause_next = pause_new;
                            ect_next   = 1'b0;
                        end
                        if (rest_decay) begin
                            level_next     = dec_level;
                            out_level_next = dec_level;
                            fc_next        = (phase_reg == PH_PAUSE_DRAW) ? FC_W'(1) :
                                                                          fc_reg + 1'b1;
                            phase_next     = PH_REST_DEC;
                        end else begin
                            out_level_next = br_level;
                            if (br_fc1 >= br_len) begin
                                fc_next  = '0;
                                bph_next = '0;
                                if (br_ect) begin
                                    phase_next = PH_PAUSE_DRAW;
                                end else begin
                                    pause_next = '0;
                                    if (beat_inc >= BEAT_W'(BEATS_PER_CYCLE)) begin
                                        beat_next        = '0;
                                        cycles_left_next = cycles_dec;
                                    end else begin
                                        beat_next        = beat_inc;
                                        cycles_left_next = cycles_left_reg;
                                    end
                                    if (cycles_left_next == '0) begin
                                        phase_next        = PH_IDLE;
                                        out_finished_next = 1'b1;
                                    end else begin
                                        phase_next = PH_LUB_ATK;
                                    end
                                end
                            end else begin
                                fc_next    = br_fc1;
                                bph_next   = (br_bph == BREATH_LAST) ? '0 : br_bph + 1'b1;
                                phase_next = PH_REST_BREATH;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Abort stops after this frame.
                if (s1_abort_reg) begin
                    phase_next        = PH_IDLE;
                    fc_next           = '0;
                    bph_next          = '0;
                    out_finished_next = 1'b1;
                end
            end
        end
    end

    // Configuration registers; the decay percent is kept pre-scaled by 1/100.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lub_peak_reg    <= LUB_PEAK_RST;
            dub_peak_reg    <= DUB_PEAK_RST;
            rest_level_reg  <= REST_LEVEL_RST;
            decay_scale_reg <= DECAY_SCALE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LUB_PEAK:      lub_peak_reg   <= cfg_data;
                CFG_DUB_PEAK:      dub_peak_reg   <= cfg_data;
                CFG_REST_LEVEL:    rest_level_reg <= cfg_data;
                CFG_DECAY_PERCENT: decay_scale_reg <=
                    DECAY_SCALE_W'(cfg_data[DECAY_W-1:0]) * DECAY_RECIP;
                default:
                begin
                end
            endcase
        end
    end

    // Control and envelope state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            level_reg       <= LEVEL_RST;
            phase_reg       <= PH_IDLE;
            fc_reg          <= '0;
            beat_reg        <= '0;
            cycles_left_reg <= '0;
            bte_reg         <= '0;
            seeded_reg      <= 1'b0;
            ect_reg         <= 1'b0;
            rest_frames_reg <= '0;
            pause_reg       <= '0;
            bph_reg         <= '0;
        end else begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            level_reg       <= level_next;
            phase_reg       <= phase_next;
            fc_reg          <= fc_next;
            beat_reg        <= beat_next;
            cycles_left_reg <= cycles_left_next;
            bte_reg         <= bte_next;
            seeded_reg      <= seeded_next;
            ect_reg         <= ect_next;
            rest_frames_reg <= rest_frames_next;
            pause_reg       <= pause_next;
            bph_reg         <= bph_next;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            s1_func_reg       <= func;
            s1_cycles_reg     <= cycles;
            s1_rand_rest_reg  <= rand_rest;
            s1_rand_gap_reg   <= rand_gap;
            s1_rand_pause_reg <= rand_pause;
            s1_abort_reg      <= abort;
        end
        out_level_reg    <= out_level_next;
        out_running_reg  <= out_running_next;
        out_finished_reg <= out_finished_next;
    end

    // A finishing beat is always a frame of a running animation.
    `HLE_ASSERT_IMPLY(a_fin_running, clk, rst_n, out_valid_reg && out_finished_reg,
        out_running_reg, "finished result without running")
    // An active envelope always has cycles left to run.
    `HLE_ASSERT_IMPLY(a_active_cycles, clk, rst_n, phase_reg != PH_IDLE,
        cycles_left_reg != '0, "active phase with no cycles left")
    // The breathing counter is idle outside the breathing phase.
    `HLE_ASSERT_IMPLY(a_bph_clear, clk, rst_n, phase_reg != PH_REST_BREATH,
        bph_reg == '0, "breathing counter set outside breathing")
    // A beat leaving the input stage always fills the result register.
    `HLE_ASSERT_NEXT(a_load_result, clk, rst_n, s2_load,
        out_valid_reg, "result register not filled after load")

endmodule
